FILE: rtl/core/adrb_pkg.sv
// Shared types and constants of the adjustable delay ring buffer.
`default_nettype none

package adrb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_W       = 13;
  localparam int DELAY_W     = 12;
  localparam int OP_W        = 2;
  localparam int DEPTH_DEF   = 4096;
  localparam int LEN_RESET   = 4096;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_SET   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_REDUCE,
    ST_RESYNC
  } back_state_t;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CFG_W-1:0]           delay_target;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [DELAY_W-1:0]         delay_now;
  } out_beat_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CFG_W-1:0]           target;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/adrb_front.sv
// Front end: accepts input beats, decodes them and saturates the delay target.
`default_nettype none

module adrb_front (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire adrb_pkg::in_beat_t            in_beat,
  input  wire logic [adrb_pkg::CFG_W-1:0]    len,
  input  wire adrb_pkg::back_status_t        back_status,
  input  wire adrb_pkg::queue_status_t       q_status,
  output logic                               q_push,
  output adrb_pkg::cmd_t                     q_wdata
);

  adrb_pkg::op_t op;

  assign op       = adrb_pkg::op_t'(in_beat.operation);
  assign in_stall = q_status.full || back_status.init_busy;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_wdata.op     = op;
    q_wdata.sample = '0;
    q_wdata.target = '0;
    case (op)
      adrb_pkg::OP_PUSH: begin
        q_wdata.sample = in_beat.sample_in;
      end
      adrb_pkg::OP_SET: begin
        // A target beyond the length lands on the length itself.
        q_wdata.target = (in_beat.delay_target > len) ? len : in_beat.delay_target;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/adrb_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module adrb_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire adrb_pkg::cmd_t          wdata,
  input  wire logic                    pop,
  output adrb_pkg::queue_status_t      status,
  output adrb_pkg::cmd_t               head
);

  localparam int QD     = adrb_pkg::QUEUE_DEPTH;
  localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCNT_W = $clog2(QD + 1);

  adrb_pkg::cmd_t    entry_r [QD];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == QCNT_W'(QD));
  assign status.empty = (cnt_r == '0);
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/adrb_back.sv
// Back end: sample store, positions, clearing sweep, position reduction and result register.
`default_nettype none

module adrb_back #(
  parameter int DEPTH = adrb_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [adrb_pkg::CFG_W-1:0]    len,
  input  wire logic                          cfg_we,
  input  wire adrb_pkg::queue_status_t       q_status,
  input  wire adrb_pkg::cmd_t                q_head,
  output logic                               q_pop,
  output adrb_pkg::back_status_t             status,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output adrb_pkg::out_beat_t                out_beat
);

  localparam int CFG_W    = adrb_pkg::CFG_W;
  localparam int SAMPLE_W = adrb_pkg::SAMPLE_W;
  localparam int DELAY_W  = adrb_pkg::DELAY_W;
  localparam int POS_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(POS_W + 1);
  localparam int AW       = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
  localparam logic [POS_W-1:0] CLR_LAST = POS_W'(DEPTH - 1);

  adrb_pkg::back_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic                init_r, init_nxt;
  logic                pending_r, pending_nxt;
  logic [POS_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [POS_W-1:0]    wp_r, wp_nxt;
  logic [POS_W-1:0]    rp_r, rp_nxt;
  logic [POS_W-1:0]    dist_r, dist_nxt;
  logic [CFG_W-1:0]    rem_w_r, rem_w_nxt;
  logic [CFG_W-1:0]    rem_r_r, rem_r_nxt;
  logic [CNT_W-1:0]    red_cnt_r, red_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                is_pull_r, is_pull_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;

  logic                out_free;
  logic                mem_we;
  logic                mem_re;
  logic [POS_W-1:0]    mem_wa;
  logic [SAMPLE_W-1:0] mem_wd;

  logic [AW-1:0]       wp_ext, rp_ext, len_ext, t_ext, dist_ext;
  logic [AW-1:0]       wp_inc, rp_inc, dist_inc, set_sum, set_red, diff, diff_fix;
  logic [CFG_W:0]      len_x, tw, tr, tw_red, tr_red;
  logic [CFG_W-1:0]    rem_w_step, rem_r_step;
  logic [POS_W+CFG_W-1:0]   rem_w_wide, rem_r_wide, tgt_wide;
  logic [POS_W+DELAY_W-1:0] dist_wide;

  assign out_free = !out_valid_r || !out_stall;

  assign wp_ext   = {{(AW-POS_W){1'b0}}, wp_r};
  assign rp_ext   = {{(AW-POS_W){1'b0}}, rp_r};
  assign dist_ext = {{(AW-POS_W){1'b0}}, dist_r};
  assign len_ext  = {{(AW-CFG_W){1'b0}}, len};
  assign t_ext    = {{(AW-CFG_W){1'b0}}, q_head.target};

  assign wp_inc   = wp_ext + 1'b1;
  assign rp_inc   = rp_ext + 1'b1;
  assign dist_inc = dist_ext + 1'b1;
  assign set_sum  = wp_ext + len_ext - t_ext;
  assign set_red  = (set_sum >= len_ext) ? set_sum - len_ext : set_sum;
  assign diff     = wp_ext - rp_ext;
  assign diff_fix = diff[AW-1] ? diff + len_ext : diff;

  // One restoring remainder step per cycle for each position.
  assign len_x      = {1'b0, len};
  assign tw         = {rem_w_r, wp_r[POS_W-1]};
  assign tr         = {rem_r_r, rp_r[POS_W-1]};
  assign tw_red     = (tw >= len_x) ? tw - len_x : tw;
  assign tr_red     = (tr >= len_x) ? tr - len_x : tr;
  assign rem_w_step = tw_red[CFG_W-1:0];
  assign rem_r_step = tr_red[CFG_W-1:0];
  assign rem_w_wide = {{POS_W{1'b0}}, rem_w_step};
  assign rem_r_wide = {{POS_W{1'b0}}, rem_r_step};
  assign tgt_wide   = {{POS_W{1'b0}}, q_head.target};
  assign dist_wide  = {{DELAY_W{1'b0}}, dist_nxt};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adrb_pkg::ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = adrb_pkg::ST_RUN;
        end
      end
      adrb_pkg::ST_RUN: begin
        if (!q_status.empty) begin
          if (pending_r) begin
            state_nxt = adrb_pkg::ST_REDUCE;
          end else if (out_free && (q_head.op == adrb_pkg::OP_CLEAR)) begin
            state_nxt = adrb_pkg::ST_CLEAR;
          end
        end
      end
      adrb_pkg::ST_REDUCE: begin
        if (red_cnt_r == '0) begin
          state_nxt = adrb_pkg::ST_RESYNC;
        end
      end
      adrb_pkg::ST_RESYNC: begin
        state_nxt = adrb_pkg::ST_RUN;
      end
      default: begin
        state_nxt = adrb_pkg::ST_CLEAR;
      end
    endcase
  end

  // State outputs: queue pop and store port controls.
  always_comb begin
    q_pop  = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = wp_r;
    mem_wd = q_head.sample;
    case (state_r)
      adrb_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      adrb_pkg::ST_RUN: begin
        q_pop  = !q_status.empty && !pending_r && out_free;
        mem_we = q_pop && (q_head.op == adrb_pkg::OP_PUSH);
        mem_re = q_pop && (q_head.op == adrb_pkg::OP_PULL);
      end
      default: begin
      end
    endcase
  end

  // Datapath.
  always_comb begin
    init_nxt      = init_r;
    pending_nxt   = pending_r || cfg_we;
    clr_cnt_nxt   = clr_cnt_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    dist_nxt      = dist_r;
    rem_w_nxt     = rem_w_r;
    rem_r_nxt     = rem_r_r;
    red_cnt_nxt   = red_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    is_pull_nxt   = is_pull_r;
    delay_nxt     = delay_r;
    case (state_r)
      adrb_pkg::ST_CLEAR: begin
        clr_cnt_nxt = (clr_cnt_r == CLR_LAST) ? '0 : clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          init_nxt = 1'b0;
        end
      end
      adrb_pkg::ST_RUN: begin
        if (!q_status.empty && pending_r) begin
          rem_w_nxt   = '0;
          rem_r_nxt   = '0;
          red_cnt_nxt = CNT_W'(POS_W - 1);
        end
        if (q_pop) begin
          case (q_head.op)
            adrb_pkg::OP_PUSH: begin
              wp_nxt   = (wp_inc == len_ext) ? '0 : wp_inc[POS_W-1:0];
              dist_nxt = (dist_inc == len_ext) ? '0 : dist_inc[POS_W-1:0];
            end
            adrb_pkg::OP_PULL: begin
              rp_nxt   = (rp_inc == len_ext) ? '0 : rp_inc[POS_W-1:0];
              dist_nxt = (dist_r == '0) ? len_ext[POS_W-1:0] - 1'b1 : dist_r - 1'b1;
            end
            adrb_pkg::OP_SET: begin
              rp_nxt   = set_red[POS_W-1:0];
              // A target equal to the length puts both positions together.
              dist_nxt = (t_ext == len_ext) ? '0 : tgt_wide[POS_W-1:0];
            end
            default: begin
              wp_nxt      = '0;
              rp_nxt      = '0;
              dist_nxt    = '0;
              pending_nxt = 1'b0;
            end
          endcase
          out_valid_nxt = 1'b1;
          is_pull_nxt   = (q_head.op == adrb_pkg::OP_PULL);
          delay_nxt     = dist_wide[DELAY_W-1:0];
        end
      end
      adrb_pkg::ST_REDUCE: begin
        rem_w_nxt   = rem_w_step;
        rem_r_nxt   = rem_r_step;
        red_cnt_nxt = red_cnt_r - 1'b1;
        if (red_cnt_r == '0) begin
          wp_nxt = rem_w_wide[POS_W-1:0];
          rp_nxt = rem_r_wide[POS_W-1:0];
        end else begin
          wp_nxt = wp_r << 1;
          rp_nxt = rp_r << 1;
        end
      end
      adrb_pkg::ST_RESYNC: begin
        dist_nxt    = diff_fix[POS_W-1:0];
        pending_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adrb_pkg::ST_CLEAR;
      init_r      <= 1'b1;
      pending_r   <= 1'b0;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      pending_r   <= pending_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_w_r   <= rem_w_nxt;
    rem_r_r   <= rem_r_nxt;
    red_cnt_r <= red_cnt_nxt;
    is_pull_r <= is_pull_nxt;
    delay_r   <= delay_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[rp_r];
    end
  end

  assign status.init_busy    = init_r;
  assign out_valid           = out_valid_r;
  assign out_beat.sample_out = is_pull_r ? rd_data_r : '0;
  assign out_beat.delay_now  = delay_r;

endmodule

`default_nettype wire

FILE: rtl/core/adjustable_delay_ring_buffer.sv
// Top level of the adjustable delay ring buffer: length register and the three stages.
// A result beat is registered in the back end after its input beat is popped from the queue.
// Throughput: one beat per cycle for push, pull and set delay while nothing stalls.
// A clear beat is followed by a sweep that zeroes every store entry before the next beat.
// The first beat after a length write waits for position reduction and a distance resync.
// Reset: synchronous, active low; a clearing pass over the store follows with in_stall high.
`default_nettype none

module adjustable_delay_ring_buffer #(
  parameter int DEPTH = adrb_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire adrb_pkg::in_beat_t            in_beat,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output adrb_pkg::out_beat_t                out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [adrb_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int CFG_W = adrb_pkg::CFG_W;
  localparam int CW    = (($clog2(DEPTH + 1) > CFG_W) ? $clog2(DEPTH + 1) : CFG_W) + 1;
  localparam int LEN_RST = (DEPTH < adrb_pkg::LEN_RESET) ? DEPTH : adrb_pkg::LEN_RESET;

  // The length register holds the clamped value, from 2 up to DEPTH, so that
  // every consumer sees a usable wrap point.
  logic [CFG_W-1:0] len_r, len_nxt;
  logic [CW-1:0]    wdata_ext;

  adrb_pkg::cmd_t          q_wdata, q_head;
  adrb_pkg::queue_status_t q_status;
  adrb_pkg::back_status_t  back_status;
  logic                    q_push, q_pop;

  assign wdata_ext = {{(CW-CFG_W){1'b0}}, cfg_wdata};

  always_comb begin
    len_nxt = len_r;
    if (cfg_we) begin
      if (wdata_ext < CW'(2)) begin
        len_nxt = CFG_W'(2);
      end else if (wdata_ext > CW'(DEPTH)) begin
        // Only reachable when DEPTH is below the register range, so it fits.
        len_nxt = CFG_W'(DEPTH);
      end else begin
        len_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= CFG_W'(LEN_RST);
    end else begin
      len_r <= len_nxt;
    end
  end

  // The front end decodes beats and saturates the delay target against the length.
  adrb_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .len         (len_r),
    .back_status (back_status),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  // The queue lets input beats land while the back end clears, reduces or waits on the output.
  adrb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .status (q_status),
    .head   (q_head)
  );

  // The back end owns the store, both positions and the result register.
  adrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len_r),
    .cfg_we    (cfg_we),
    .q_status  (q_status),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .status    (back_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire
